/* hw/rtl/gii_pkg.sv */
// ============================================================================
// gii_pkg
// Shared types, widths and constants of the grey integral image block.
// ============================================================================
package gii_pkg;

    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned MAX_HEIGHT  = 1024;

    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned GREY_W      = 8;
    localparam int unsigned SIZE_W      = 11;
    localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
    localparam int unsigned ROW_SUM_W   = 18;
    localparam int unsigned INTEGRAL_W  = 28;

    localparam int unsigned CSUM_W      = COLOR_W + 2;
    localparam int unsigned THIRD_MULT  = 683;
    localparam int unsigned THIRD_SHIFT = 11;
    localparam int unsigned PROD_W      = CSUM_W + 10;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic [COL_W-1:0]  col;
        logic              top_row;
        logic              frame_last;
    } job_t;

    function automatic logic [COL_W:0] eff_col_size(logic [SIZE_W-1:0] v);
        logic [COL_W:0] r;
        if (v == '0)
            r = (COL_W+1)'(1);
        else if (32'(v) > MAX_WIDTH)
            r = (COL_W+1)'(MAX_WIDTH);
        else
            r = (COL_W+1)'(v);
        return r;
    endfunction

    function automatic logic [ROW_W:0] eff_row_size(logic [SIZE_W-1:0] v);
        logic [ROW_W:0] r;
        if (v == '0)
            r = (ROW_W+1)'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = (ROW_W+1)'(MAX_HEIGHT);
        else
            r = (ROW_W+1)'(v);
        return r;
    endfunction

endpackage

/* hw/rtl/gii_if.sv */
// ============================================================================
// gii_if
// Valid/ready channels of the grey integral image block.
// ============================================================================
interface gii_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [gii_pkg::COLOR_W-1:0] red;
    logic [gii_pkg::COLOR_W-1:0] green;
    logic [gii_pkg::COLOR_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface gii_result_if;
    logic                          valid;
    logic                          ready;
    logic [gii_pkg::GREY_W-1:0]     grey_level;
    logic [gii_pkg::INTEGRAL_W-1:0] integral_sum;
    logic                          frame_last;

    modport source (output valid, grey_level, integral_sum, frame_last, input ready);
    modport sink   (input valid, grey_level, integral_sum, frame_last, output ready);
endinterface

interface gii_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [gii_pkg::CFG_IDX_W-1:0] index;
    logic [gii_pkg::SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/gii_ram.sv */
// ============================================================================
// gii_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module gii_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/gii_front.sv */
// ============================================================================
// gii_front
// Pixel intake: grey conversion, raster position, frame size registers.
// ============================================================================
module gii_front (
    input  logic             clk,
    input  logic             rst_n,
    gii_pixel_if.sink        pixel,
    gii_cfg_if.sink          cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output gii_pkg::job_t    push_job
);

    logic [gii_pkg::SIZE_W-1:0]  width_reg;
    logic [gii_pkg::SIZE_W-1:0]  height_reg;
    logic [gii_pkg::COL_W-1:0]   col_reg;
    logic [gii_pkg::COL_W-1:0]   col_next;
    logic [gii_pkg::ROW_W-1:0]   row_reg;
    logic [gii_pkg::ROW_W-1:0]   row_next;

    logic [gii_pkg::CSUM_W-1:0]  csum;
    logic [gii_pkg::PROD_W-1:0]  prod;
    logic [gii_pkg::COL_W:0]     w_eff;
    logic [gii_pkg::ROW_W:0]     h_eff;
    logic                        last_col;
    logic                        last_row;
    logic                        beat;

    assign cfg.ready = 1'b1;

    assign csum = gii_pkg::CSUM_W'(pixel.red) + gii_pkg::CSUM_W'(pixel.green)
                + gii_pkg::CSUM_W'(pixel.blue);
    assign prod = gii_pkg::PROD_W'(csum) * gii_pkg::PROD_W'(gii_pkg::THIRD_MULT);

    assign w_eff    = gii_pkg::eff_col_size(width_reg);
    assign h_eff    = gii_pkg::eff_row_size(height_reg);
    assign last_col = ({1'b0, col_reg} + (gii_pkg::COL_W+1)'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + (gii_pkg::ROW_W+1)'(1)) >= h_eff;

    assign beat        = pixel.valid && push_ready;
    assign pixel.ready = push_ready;
    assign push_valid  = pixel.valid;

    always_comb
    begin
        push_job.grey       = prod[gii_pkg::THIRD_SHIFT +: gii_pkg::GREY_W];
        push_job.col        = col_reg;
        push_job.top_row    = (row_reg == '0);
        push_job.frame_last = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (beat)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + gii_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + gii_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gii_pkg::FRAME_WIDTH_RESET;
            height_reg <= gii_pkg::FRAME_HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg.valid)
            begin
                if (cfg.index == gii_pkg::REG_FRAME_WIDTH)
                begin
                    width_reg <= cfg.data;
                end
                else if (cfg.index == gii_pkg::REG_FRAME_HEIGHT)
                begin
                    height_reg <= cfg.data;
                end
            end
        end
    end

endmodule

/* hw/rtl/gii_queue.sv */
// ============================================================================
// gii_queue
// Short flop queue of jobs between intake and accumulation.
// ============================================================================
module gii_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  gii_pkg::job_t    push_job,
    output logic             pop_valid,
    input  logic             pop_ready,
    output gii_pkg::job_t    pop_job
);

    gii_pkg::job_t                entry_reg [gii_pkg::QUEUE_DEPTH];
    logic [gii_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [gii_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [gii_pkg::QCNT_W-1:0]   count_reg;
    logic                         push;
    logic                         pop;

    assign push_ready = (32'(count_reg) < gii_pkg::QUEUE_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == gii_pkg::QUEUE_DEPTH - 1)
                            ? '0 : wr_ptr_reg + gii_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == gii_pkg::QUEUE_DEPTH - 1)
                            ? '0 : rd_ptr_reg + gii_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + gii_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - gii_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/gii_back.sv */
// ============================================================================
// gii_back
// Accumulation: row running sum, line buffer of the row above, result stage.
// ============================================================================
module gii_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  gii_pkg::job_t    pop_job,
    gii_result_if.source     result
);

    gii_pkg::job_t                    b1_job_reg;
    logic                             b1_valid_reg;
    logic                             byp_reg;
    logic [gii_pkg::INTEGRAL_W-1:0]   byp_val_reg;
    logic [gii_pkg::ROW_SUM_W-1:0]    row_sum_reg;
    logic [gii_pkg::ROW_SUM_W-1:0]    row_sum_next;

    logic                             out_valid_reg;
    logic [gii_pkg::GREY_W-1:0]       out_grey_reg;
    logic [gii_pkg::INTEGRAL_W-1:0]   out_integral_reg;
    logic                             out_last_reg;

    logic                             out_free;
    logic                             b1_move;
    logic                             load;
    logic [gii_pkg::INTEGRAL_W-1:0]   rd_data;
    logic [gii_pkg::INTEGRAL_W-1:0]   above;
    logic [gii_pkg::INTEGRAL_W-1:0]   integral;

    assign out_free  = !out_valid_reg || result.ready;
    assign b1_move   = b1_valid_reg && out_free;
    assign pop_ready = !b1_valid_reg || out_free;
    assign load      = pop_valid && pop_ready;

    gii_ram #(
        .WIDTH (gii_pkg::INTEGRAL_W),
        .DEPTH (gii_pkg::MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (b1_move),
        .wr_addr (b1_job_reg.col),
        .wr_data (integral),
        .rd_en   (load),
        .rd_addr (pop_job.col),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (b1_job_reg.top_row)
            above = '0;
        else if (byp_reg)
            above = byp_val_reg;
        else
            above = rd_data;
    end

    assign integral = above + gii_pkg::INTEGRAL_W'(row_sum_reg);

    assign row_sum_next = (pop_job.col == '0)
                        ? gii_pkg::ROW_SUM_W'(pop_job.grey)
                        : row_sum_reg + gii_pkg::ROW_SUM_W'(pop_job.grey);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b1_job_reg  <= pop_job;
            byp_reg     <= b1_move && (b1_job_reg.col == pop_job.col);
            byp_val_reg <= integral;
            row_sum_reg <= row_sum_next;
        end
        if (b1_move)
        begin
            out_grey_reg     <= b1_job_reg.grey;
            out_integral_reg <= integral;
            out_last_reg     <= b1_job_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                b1_valid_reg <= pop_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.grey_level   = out_grey_reg;
    assign result.integral_sum = out_integral_reg;
    assign result.frame_last   = out_last_reg;

endmodule

/* hw/rtl/grey_integral_image.sv */
// ============================================================================
// grey_integral_image
// Grey conversion and summed-area table of a raster pixel stream.
//
//   channel  dir  beat payload
//   pixel    in   red, green, blue
//   result   out  grey_level, integral_sum, frame_last
//   cfg      in   index (0 frame_width, 1 frame_height), data
//
// One pixel per cycle while the result side does not stall; result valid
// rises after the queue, the line buffer read and the output register.
// The line buffer has one registered read and one write port; back-to-back
// access to the same column is forwarded from the result stage.
// Reset zeroes position, sizes to 1024; the line buffer needs no clearing.
// Either side may stall; the queue absorbs two beats.
// ============================================================================
module grey_integral_image (
    input  logic          clk,
    input  logic          rst_n,
    gii_pixel_if.sink     pixel,
    gii_result_if.source  result,
    gii_cfg_if.sink       cfg
);

    logic            push_valid;
    logic            push_ready;
    gii_pkg::job_t   push_job;
    logic            pop_valid;
    logic            pop_ready;
    gii_pkg::job_t   pop_job;

    gii_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    gii_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    gii_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_pixel_enters_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |-> (push_valid && push_ready))
        else $error("pixel beat not pushed to queue");

    a_pop_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> ($past(push_valid && push_ready) || $past(pop_valid)))
        else $error("queue shows a job that was never pushed");

    a_first_pixel_top: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && push_job.frame_last)
        |=> (push_job.col == '0 && push_job.top_row))
        else $error("position not wrapped after last pixel of frame");
`endif

endmodule
